/* design/counting_semaphore_fifo_waitq_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITQ_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITQ_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CSFWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CSFWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/csfwq_pkg.sv */
`timescale 1ns / 1ps
package csfwq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int ID_MAX_W         = 16;

  localparam int FUNC_W   = 2;
  localparam int IN_ID_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;
  localparam int INIT_W   = 15;

  localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PASSED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOKE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sh8000;

  typedef enum logic {
    CTL_EMPTY,
    CTL_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic exec;
    logic cfg_load;
  } dp_cmd_t;

endpackage

/* design/csfwq_ctrl.sv */
`timescale 1ns / 1ps
module csfwq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  output csfwq_pkg::dp_cmd_t cmd
);
  import csfwq_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    out_valid    = 1'b0;
    in_ready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.cfg_load = cfg_we;
    case (state_r)
      CTL_EMPTY: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
        if (in_valid) begin
          state_nxt = CTL_HOLD;
        end
      end
      CTL_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.exec  = in_valid && out_ready;
        if (out_ready && !in_valid) begin
          state_nxt = CTL_EMPTY;
        end
      end
      default: begin
        state_nxt = CTL_EMPTY;
      end
    endcase
  end

endmodule

/* design/csfwq_dp.sv */
`timescale 1ns / 1ps
module csfwq_dp #(
  parameter int QUEUE_DEPTH  = csfwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csfwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  csfwq_pkg::dp_cmd_t                      cmd,
  input  logic [csfwq_pkg::INIT_W-1:0]            cfg_value,
  input  logic [csfwq_pkg::FUNC_W-1:0]            func,
  input  logic [csfwq_pkg::IN_ID_W-1:0]           task_id,
  output logic [csfwq_pkg::STATUS_W-1:0]          status,
  output logic [csfwq_pkg::IN_ID_W-1:0]           woken_task_id,
  output logic                                    woken_valid,
  output logic signed [csfwq_pkg::COUNT_W-1:0]    count_after
);
  import csfwq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [TASK_ID_BITS-1:0] q_r   [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] q_nxt [QUEUE_DEPTH];
  logic [OCC_W-1:0]        occ_r;
  logic [OCC_W-1:0]        occ_nxt;
  logic signed [COUNT_W-1:0] count_r;
  logic signed [COUNT_W-1:0] count_nxt;
  logic [STATUS_W-1:0]     status_r;
  logic [STATUS_W-1:0]     status_nxt;
  logic [IN_ID_W-1:0]      woken_r;
  logic [IN_ID_W-1:0]      woken_nxt;
  logic                    wvalid_r;
  logic                    wvalid_nxt;

  logic [ID_MAX_W-1:0]     id_ext;
  logic [TASK_ID_BITS-1:0] id;
  logic [ID_MAX_W-1:0]     wk_ext;
  logic [TASK_ID_BITS-1:0] wk_sel;
  logic [QUEUE_DEPTH-1:0]  match;
  logic [QUEUE_DEPTH-1:0]  rm_mask;
  logic [QUEUE_DEPTH-1:0]  drop_mask;
  logic                    found;
  logic                    q_full;
  logic                    q_empty;
  logic                    do_push;
  logic                    do_drop;
  logic                    run;
  logic signed [COUNT_W-1:0] cnt_inc;
  logic signed [COUNT_W-1:0] cnt_dec;

  always_comb begin
    id_ext = {{(ID_MAX_W - IN_ID_W){1'b0}}, task_id};
    id     = id_ext[TASK_ID_BITS-1:0];
  end

  // parallel id match with first-match prefix mask
  always_comb begin
    run = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i]   = (OCC_W'(i) < occ_r) && (q_r[i] == id);
      run        = run | match[i];
      rm_mask[i] = run;
    end
    found = run;
  end

  assign q_full  = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign q_empty = (occ_r == '0);
  assign cnt_inc = (count_r == COUNT_MAX) ? count_r : count_r + 16'sd1;
  assign cnt_dec = (count_r == COUNT_MIN) ? count_r : count_r - 16'sd1;

  always_comb begin
    count_nxt  = count_r;
    occ_nxt    = occ_r;
    status_nxt = ST_REMOVED;
    wvalid_nxt = 1'b0;
    wk_sel     = '0;
    do_push    = 1'b0;
    do_drop    = 1'b0;
    drop_mask  = rm_mask;
    case (func)
      FUNC_WAIT: begin
        if (cnt_dec < 0) begin
          if (q_full) begin
            status_nxt = ST_FULL;
          end else begin
            do_push    = 1'b1;
            occ_nxt    = occ_r + OCC_W'(1);
            count_nxt  = cnt_dec;
            status_nxt = ST_BLOCKED;
          end
        end else begin
          count_nxt  = cnt_dec;
          status_nxt = ST_PASSED;
        end
      end
      FUNC_SIGNAL: begin
        count_nxt  = cnt_inc;
        status_nxt = ST_NONE;
        drop_mask  = '1;
        if ((cnt_inc <= 0) && !q_empty) begin
          wk_sel     = q_r[0];
          wvalid_nxt = 1'b1;
          do_drop    = 1'b1;
          occ_nxt    = occ_r - OCC_W'(1);
          status_nxt = ST_WOKE;
        end
      end
      FUNC_REMOVE: begin
        if (found) begin
          wk_sel     = id;
          wvalid_nxt = 1'b1;
          do_drop    = 1'b1;
          occ_nxt    = occ_r - OCC_W'(1);
          count_nxt  = cnt_inc;
        end
      end
      default: begin
        status_nxt = ST_REMOVED;
      end
    endcase
    wk_ext                     = '0;
    wk_ext[TASK_ID_BITS-1:0]   = wk_sel;
    woken_nxt                  = wk_ext[IN_ID_W-1:0];
  end

  // shift queue: close the gap on drop, write the tail on push
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (do_drop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (drop_mask[i]) begin
          q_nxt[i] = q_r[i+1];
        end
      end
    end
    if (do_push) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (OCC_W'(i) == occ_r) begin
          q_nxt[i] = id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      occ_r   <= '0;
    end else if (cmd.cfg_load) begin
      count_r <= {1'b0, cfg_value};
      occ_r   <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        q_r[i] <= q_nxt[i];
      end
      status_r <= status_nxt;
      woken_r  <= woken_nxt;
      wvalid_r <= wvalid_nxt;
    end
  end

  assign status        = status_r;
  assign woken_task_id = woken_r;
  assign woken_valid   = wvalid_r;
  assign count_after   = count_r;

endmodule

/* design/counting_semaphore_fifo_waitq_core.sv */
`timescale 1ns / 1ps
// Counting semaphore with a FIFO wait queue of blocked task ids.
// Input channel (in_valid/in_ready): one beat carries in_func (wait, signal,
// remove named waiter) and in_task_id. Output channel (out_valid/out_ready):
// one beat per input beat with out_status, out_woken_task_id,
// out_woken_valid and out_count_after.
// Latency: the result beat is valid the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_ready is high; the queue is a
// shift register with a parallel id match, so every operation settles in a single update.
// Stall: while a result waits, a new input beat is taken only in a cycle in
// which out_ready is high; the output register holds its beat otherwise.
// Configuration: a cfg_we pulse loads the count from cfg_wdata and empties
// the queue; write it only with no beat in flight.
// Reset (rst_n low, synchronous): count zero, queue empty, no result pending.
module counting_semaphore_fifo_waitq_core #(
  parameter int QUEUE_DEPTH  = csfwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csfwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [csfwq_pkg::FUNC_W-1:0]         in_func,
  input  logic [csfwq_pkg::IN_ID_W-1:0]        in_task_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [csfwq_pkg::STATUS_W-1:0]       out_status,
  output logic [csfwq_pkg::IN_ID_W-1:0]        out_woken_task_id,
  output logic                                 out_woken_valid,
  output logic signed [csfwq_pkg::COUNT_W-1:0] out_count_after,
  input  logic                                 cfg_we,
  input  logic [csfwq_pkg::INIT_W-1:0]         cfg_wdata
);
  import csfwq_pkg::*;

  dp_cmd_t cmd;

  csfwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cmd       (cmd)
  );

  csfwq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_value     (cfg_wdata),
    .func          (in_func),
    .task_id       (in_task_id),
    .status        (out_status),
    .woken_task_id (out_woken_task_id),
    .woken_valid   (out_woken_valid),
    .count_after   (out_count_after)
  );

endmodule

/* design/csfwq_checker.sv */
`timescale 1ns / 1ps
`include "counting_semaphore_fifo_waitq_core_assert.svh"
module csfwq_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [csfwq_pkg::STATUS_W-1:0]       out_status,
  input logic [csfwq_pkg::IN_ID_W-1:0]        out_woken_task_id,
  input logic                                 out_woken_valid,
  input logic signed [csfwq_pkg::COUNT_W-1:0] out_count_after
);
  import csfwq_pkg::*;

  `CSFWQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_woken_task_id) && $stable(out_count_after), "result beat changed while stalled")
  `CSFWQ_ASSERT_IMPL(a_woken_status, out_valid && out_woken_valid, (out_status == ST_WOKE) || (out_status == ST_REMOVED), "woken task on a status that wakes none")
  `CSFWQ_ASSERT_IMPL(a_blocked_neg, out_valid && (out_status == ST_BLOCKED), out_count_after < 0, "blocked with count not negative")
  `CSFWQ_ASSERT_IMPL(a_passed_pos, out_valid && (out_status == ST_PASSED), out_count_after >= 0, "passed with negative count")
  `CSFWQ_ASSERT_IMPL(a_no_woken_zero, out_valid && !out_woken_valid, out_woken_task_id == '0, "woken id set with none woken")

endmodule

bind counting_semaphore_fifo_waitq_core csfwq_checker u_csfwq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_woken_task_id (out_woken_task_id),
  .out_woken_valid   (out_woken_valid),
  .out_count_after   (out_count_after)
);

/* bench/tb_counting_semaphore_fifo_waitq_core.sv */
`timescale 1ns / 1ps
module tb_counting_semaphore_fifo_waitq_core;
  import csfwq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [IN_ID_W-1:0] id;
  } sem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [IN_ID_W-1:0]        woken_id;
    logic                      woken_valid;
    logic signed [COUNT_W-1:0] count_after;
  } sem_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_WAIT;
  logic [IN_ID_W-1:0] in_task_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [IN_ID_W-1:0] out_woken_task_id;
  logic out_woken_valid;
  logic signed [COUNT_W-1:0] out_count_after;
  logic cfg_we = 1'b0;
  logic [INIT_W-1:0] cfg_wdata = '0;

  sem_req_t op_backlog[$];
  sem_result_t sem_expected[$];
  logic [IN_ID_W-1:0] blocked_ids[$];
  logic signed [COUNT_W-1:0] sem_count = '0;

  int mismatches = 0;
  int stall_cycles = 0;
  int send_gap = 0;
  int recv_hold = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  sem_req_t req;
  sem_result_t want;

  counting_semaphore_fifo_waitq_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_task_id        (in_task_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_woken_task_id (out_woken_task_id),
    .out_woken_valid   (out_woken_valid),
    .out_count_after   (out_count_after),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic signed [COUNT_W-1:0] count_up(input logic signed [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 16'sd1;
  endfunction

  function automatic sem_result_t semaphore_op(input logic [FUNC_W-1:0] op,
                                               input logic [IN_ID_W-1:0] id);
    sem_result_t r;
    logic signed [COUNT_W-1:0] next;
    int hit;
    r.status = ST_REMOVED;
    r.woken_id = '0;
    r.woken_valid = 1'b0;
    hit = -1;
    case (op)
      FUNC_WAIT: begin
        next = (sem_count == COUNT_MIN) ? COUNT_MIN : sem_count - 16'sd1;
        if (next < 0) begin
          if (blocked_ids.size() >= QDEPTH) begin
            r.status = ST_FULL;
          end else begin
            blocked_ids.push_back(id);
            sem_count = next;
            r.status = ST_BLOCKED;
          end
        end else begin
          sem_count = next;
          r.status = ST_PASSED;
        end
      end
      FUNC_SIGNAL: begin
        sem_count = count_up(sem_count);
        r.status = ST_NONE;
        if (sem_count <= 0 && blocked_ids.size() > 0) begin
          r.woken_id = blocked_ids.pop_front();
          r.woken_valid = 1'b1;
          r.status = ST_WOKE;
        end
      end
      FUNC_REMOVE: begin
        foreach (blocked_ids[i])
          if (hit < 0 && blocked_ids[i] == id) hit = i;
        if (hit >= 0) begin
          blocked_ids.delete(hit);
          r.woken_id = id;
          r.woken_valid = 1'b1;
          sem_count = count_up(sem_count);
        end
      end
      default: ;
    endcase
    r.count_after = sem_count;
    return r;
  endfunction

  task automatic report_field(input string fld, input int exp_v, input int act_v);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, fld, exp_v, act_v);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        sem_expected.push_back(semaphore_op(in_func, in_task_id));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          req = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_func <= req.op;
          in_task_id <= req.id;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sem_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d count %0d",
                   $time, out_status, out_count_after);
          mismatches++;
        end else begin
          want = sem_expected.pop_front();
          if (out_status !== want.status)
            report_field("status", want.status, out_status);
          if (out_woken_task_id !== want.woken_id)
            report_field("woken_task_id", want.woken_id, out_woken_task_id);
          if (out_woken_valid !== want.woken_valid)
            report_field("woken_valid", want.woken_valid, out_woken_valid);
          if (out_count_after !== want.count_after)
            report_field("count_after", want.count_after, out_count_after);
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_hold = recv_burst ? 0 : $urandom_range(0, 14);
      end else if (recv_hold != 0) begin
        recv_hold--;
      end
      out_ready <= (recv_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic queue_op(input logic [FUNC_W-1:0] op, input logic [IN_ID_W-1:0] id);
    sem_req_t r;
    r.op = op;
    r.id = id;
    op_backlog.push_back(r);
  endtask

  task automatic queue_random(input int n);
    int wait_pct;
    int r;
    logic [IN_ID_W-1:0] id;
    wait_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) wait_pct = $urandom_range(0, 1) ? 80 : 30;
      // draw ids mostly from a small pool so removes hit queued waiters
      id = ($urandom_range(0, 3) == 0) ? IN_ID_W'($urandom_range(0, 255)) :
                                         IN_ID_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < wait_pct) begin
        queue_op(FUNC_WAIT, id);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) queue_op(FUNC_SIGNAL, id);
        else if (r < 9) queue_op(FUNC_REMOVE, id);
        else queue_op(FUNC_NOP, id);
      end
    end
  endtask

  task automatic settle();
    while (op_backlog.size() != 0 || in_valid || sem_expected.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_count(input logic [INIT_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sem_count = {1'b0, v};
    blocked_ids.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_op(FUNC_WAIT, 8'h00);
    queue_op(FUNC_WAIT, 8'hFF);
    queue_op(FUNC_WAIT, 8'hAA);
    queue_op(FUNC_WAIT, 8'hFF);
    queue_op(FUNC_REMOVE, 8'hFF);
    queue_op(FUNC_REMOVE, 8'h55);
    queue_op(FUNC_NOP, 8'hFF);
    queue_op(FUNC_SIGNAL, 8'h00);
    queue_op(FUNC_SIGNAL, 8'hFF);
    queue_op(FUNC_SIGNAL, 8'h00);
    queue_op(FUNC_SIGNAL, 8'h00);
    queue_op(FUNC_WAIT, 8'h01);

    load_count(15'h7FFF);
    queue_op(FUNC_SIGNAL, 8'h00);
    queue_op(FUNC_WAIT, 8'hFF);

    load_count('0);
    queue_random(600);
    load_count(15'd1);
    queue_random(300);
    load_count(15'h7FFF);
    queue_random(40);
    load_count(INIT_W'($urandom_range(0, 20)));
    queue_random(300);
    load_count(INIT_W'($urandom_range(0, 32767)));
    queue_random(100);
    load_count('0);
    queue_random(300);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
